[rtl/qct_pkg.sv]
// ----------------------------------------------------------------------------
// qct_pkg: shared types and constants of the query character tokenizer
// Token kinds, scanner modes, the result group passed from front to back,
// and the keyword lookup used when a word closes.
// ----------------------------------------------------------------------------
package qct_pkg;

  localparam int KeywordCharsDef = 6;
  localparam int QueueDepth      = 4;
  localparam int MaxResults      = 4;

  localparam logic [7:0] CharSemi   = 8'h3B;
  localparam logic [7:0] CharSingle = 8'h27;
  localparam logic [7:0] CharDouble = 8'h22;
  localparam logic [7:0] CharSpace  = 8'h20;

  localparam logic [47:0] KwInsert = "INSERT";
  localparam logic [47:0] KwSearch = "SEARCH";
  localparam logic [47:0] KwDelete = "DELETE";
  localparam logic [47:0] KwUpdate = "UPDATE";

  typedef enum logic [3:0] {
    TkDataChar  = 4'd0,
    TkDataEnd   = 4'd1,
    TkIdChar    = 4'd2,
    TkIdEnd     = 4'd3,
    TkInsert    = 4'd4,
    TkSearch    = 4'd5,
    TkDelete    = 4'd6,
    TkUpdate    = 4'd7,
    TkEndMarker = 4'd8,
    TkUnclosed  = 4'd9,
    TkUnknown   = 4'd10,
    TkBadChar   = 4'd11
  } token_kind_e;

  typedef enum logic [2:0] {
    ModeIdle  = 3'd0,
    ModeQuote = 3'd1,
    ModeId    = 3'd2,
    ModeWord  = 3'd3,
    ModeSkip  = 3'd4
  } scan_mode_e;

  // All results caused by one character. Only data and id chars carry text,
  // and there is at most one of them per character.
  typedef struct packed {
    logic [2:0]                   count;
    token_kind_e [MaxResults-1:0] kinds;
    logic [7:0]                   text;
  } qct_group_t;

  function automatic token_kind_e word_kind(input logic [47:0] letters,
                                            input logic [2:0] length);
    token_kind_e k;
    k = TkUnknown;
    if (length == 3'd6) begin
      if (letters == KwInsert)      k = TkInsert;
      else if (letters == KwSearch) k = TkSearch;
      else if (letters == KwDelete) k = TkDelete;
      else if (letters == KwUpdate) k = TkUpdate;
    end
    return k;
  endfunction

endpackage

[rtl/qct_char_if.sv]
// ----------------------------------------------------------------------------
// qct_char_if: query character channel
// One word is one character of the query and its end-of-query flag.
// ----------------------------------------------------------------------------
interface qct_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] query_char;
  logic       end_of_query;

  modport source (output valid, output query_char, output end_of_query, input ready);
  modport sink   (input valid, input query_char, input end_of_query, output ready);
endinterface

[rtl/qct_token_if.sv]
// ----------------------------------------------------------------------------
// qct_token_if: token result channel
// One word is one token result with its kind, text and run flag.
// ----------------------------------------------------------------------------
interface qct_token_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic [7:0] text_char;
  logic       last_of_run;

  modport source (output valid, output token_kind, output text_char, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input text_char, input last_of_run,
                  output ready);
endinterface

[rtl/qct_front.sv]
// ----------------------------------------------------------------------------
// qct_front: character scanner
// Holds the scan state, classifies each character and forms the group of
// results it causes.
// ----------------------------------------------------------------------------
module qct_front
  import qct_pkg::*;
#(
  parameter int KEYWORD_CHARS = KeywordCharsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] char_i,
  input  logic       eoq_i,
  input  logic       space_i,
  output logic       accept_o,
  output logic       push_o,
  output qct_group_t group_o
);

  localparam int BufW = 8 * KEYWORD_CHARS;

  scan_mode_e       mode_q, mode_d;
  logic             dq_q, dq_d;
  logic [BufW-1:0]  buf_q, buf_d;
  logic [2:0]       len_q, len_d;

  logic             is_digit, is_letter, do_start;
  logic [7:0]       upper, closer;
  logic [2:0]       n;
  token_kind_e [MaxResults-1:0] kinds;
  token_kind_e      close_kind;

  assign accept_o  = valid_i && space_i;
  assign is_digit  = char_i inside {[8'h30:8'h39]};
  assign is_letter = char_i inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  assign upper     = (char_i inside {[8'h61:8'h7A]}) ? char_i - 8'd32 : char_i;
  assign closer    = dq_q ? CharDouble : CharSingle;

  always_comb begin
    mode_d   = mode_q;
    dq_d     = dq_q;
    buf_d    = buf_q;
    len_d    = len_q;
    n        = 3'd0;
    kinds    = '{default: TkDataChar};
    do_start = 1'b0;

    case (mode_q)
      ModeQuote: begin
        if (char_i == closer) begin
          kinds[n[1:0]] = TkDataEnd; n = n + 3'd1;
          mode_d = ModeIdle;
        end else if (char_i == CharSemi) begin
          kinds[n[1:0]] = TkUnclosed; n = n + 3'd1;
          mode_d = ModeSkip;
        end else begin
          kinds[n[1:0]] = TkDataChar; n = n + 3'd1;
        end
      end
      ModeId: begin
        if (is_digit) begin
          kinds[n[1:0]] = TkIdChar; n = n + 3'd1;
        end else begin
          kinds[n[1:0]] = TkIdEnd; n = n + 3'd1;
          do_start = 1'b1;
        end
      end
      ModeWord: begin
        if (is_letter) begin
          if ({1'b0, len_q} < 4'(KEYWORD_CHARS)) buf_d = {buf_q[BufW-9:0], upper};
          if (len_q != 3'd7) len_d = len_q + 3'd1;
        end else begin
          kinds[n[1:0]] = word_kind(buf_q[47:0], len_q); n = n + 3'd1;
          do_start = 1'b1;
        end
      end
      ModeSkip: begin
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    // A character seen with no token open.
    if (do_start) begin
      if (char_i == CharSingle || char_i == CharDouble) begin
        mode_d = ModeQuote;
        dq_d   = (char_i == CharDouble);
      end else if (char_i == CharSpace) begin
        mode_d = ModeIdle;
      end else if (char_i == CharSemi) begin
        mode_d = ModeSkip;
      end else if (is_digit) begin
        mode_d = ModeId;
        kinds[n[1:0]] = TkIdChar; n = n + 3'd1;
      end else if (is_letter) begin
        mode_d = ModeWord;
        buf_d  = BufW'(upper);
        len_d  = 3'd1;
      end else begin
        mode_d = ModeIdle;
        kinds[n[1:0]] = TkBadChar; n = n + 3'd1;
      end
    end

    close_kind = word_kind(buf_d[47:0], len_d);
    if (eoq_i) begin
      if (mode_d == ModeQuote) begin
        kinds[n[1:0]] = TkUnclosed; n = n + 3'd1;
      end else if (mode_d == ModeId) begin
        kinds[n[1:0]] = TkIdEnd; n = n + 3'd1;
      end else if (mode_d == ModeWord) begin
        kinds[n[1:0]] = close_kind; n = n + 3'd1;
      end
      kinds[n[1:0]] = TkEndMarker; n = n + 3'd1;
      mode_d = ModeIdle;
      dq_d   = 1'b0;
      buf_d  = '0;
      len_d  = 3'd0;
    end
  end

  assign push_o        = accept_o && (n != 3'd0);
  assign group_o.count = n;
  assign group_o.kinds = kinds;
  assign group_o.text  = char_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      dq_q   <= 1'b0;
      buf_q  <= '0;
      len_q  <= 3'd0;
    end else if (accept_o) begin
      mode_q <= mode_d;
      dq_q   <= dq_d;
      buf_q  <= buf_d;
      len_q  <= len_d;
    end
  end

`ifndef SYNTHESIS
  a_idle_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_o && eoq_i |=> mode_q == ModeIdle && len_q == 3'd0)
    else $error("scanner not back to idle after end of query");

  a_word_has_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModeWord |-> len_q != 3'd0)
    else $error("word mode with no letters");

  a_end_closes_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_o && eoq_i |-> push_o && group_o.kinds[n[1:0] - 2'd1] == TkEndMarker)
    else $error("end of query without end marker last");
`endif

endmodule

[rtl/qct_fifo.sv]
// ----------------------------------------------------------------------------
// qct_fifo: result group queue
// Small flop-based queue that decouples the scanner from the token output.
// ----------------------------------------------------------------------------
module qct_fifo
  import qct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  qct_group_t data_i,
  output logic       space_o,
  output logic       valid_o,
  input  logic       pop_i,
  output qct_group_t data_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  qct_group_t            mem_q [QueueDepth];
  logic [PtrW-1:0]       wr_q, rd_q;
  logic [CntW-1:0]       cnt_q, cnt_d;

  assign space_o = cnt_q != CntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      if (pop_i)  rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> space_o || pop_i)
    else $error("queue written while full");
`endif

endmodule

[rtl/qct_back.sv]
// ----------------------------------------------------------------------------
// qct_back: token emitter
// Walks through each queued result group one token per cycle into an
// output register, while that register is empty or its token is being taken.
// ----------------------------------------------------------------------------
module qct_back
  import qct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  qct_group_t group_i,
  output logic       pop_o,
  qct_token_if.source token_o
);

  logic [1:0]  idx_q;
  logic        load, last_one;
  token_kind_e kind;
  logic        out_valid_q;
  token_kind_e out_kind_q;
  logic [7:0]  out_char_q;
  logic        out_last_q;

  assign load     = valid_i && (!out_valid_q || token_o.ready);
  assign kind     = group_i.kinds[idx_q];
  assign last_one = {1'b0, idx_q} == group_i.count - 3'd1;
  assign pop_o    = load && last_one;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last_one ? 2'd0 : idx_q + 2'd1;
      end else if (token_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q <= kind;
      out_char_q <= (kind == TkDataChar || kind == TkIdChar) ? group_i.text : 8'd0;
      out_last_q <= last_one;
    end
  end

  assign token_o.valid       = out_valid_q;
  assign token_o.token_kind  = out_kind_q;
  assign token_o.text_char   = out_char_q;
  assign token_o.last_of_run = out_last_q;

endmodule

[rtl/query_char_tokenizer_unit.sv]
// ----------------------------------------------------------------------------
// query_char_tokenizer_unit: query text tokenizer
// Turns a stream of query characters into data, id, keyword and error
// tokens.
// ----------------------------------------------------------------------------
// Usage:
// The char_i channel takes one word per cycle while the queue has room: a
// query character and a flag that marks the last character of the query. The
// token_o channel gives one word per token: its kind, its text character and
// a flag on the last token caused by a character. Both channels move a word
// when valid and ready are high at a rising clock edge.
// Throughput is one character per cycle while the queue has room; a character
// that causes several tokens (up to four, as when a word is closed by a digit
// that ends the query) holds the token port while its tokens go out in turn,
// and the four-group queue between the scanner and the emitter absorbs that.
// Characters that cause no token (spaces between tokens, letters inside a
// word, text after a semicolon) only update the scanner. The first token of a
// character passes through the queue and then the output register. When the
// receiver stalls, the output register holds its word and the scanner keeps
// taking characters until the queue is full. Reset clears the scanner to
// idle, empties the queue and drops any pending token.
// ----------------------------------------------------------------------------
module query_char_tokenizer_unit
  import qct_pkg::*;
#(
  parameter int KEYWORD_CHARS = KeywordCharsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qct_char_if.sink    char_i,
  qct_token_if.source token_o
);

  // Front to queue.
  logic       accept, push, space;
  qct_group_t push_group;

  // Queue to back.
  logic       q_valid, pop;
  qct_group_t head_group;

  assign char_i.ready = space;

  // Scanner: classifies each character against the open token, closes tokens
  // and forms the group of results for that character.
  qct_front #(
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (char_i.valid),
    .char_i  (char_i.query_char),
    .eoq_i   (char_i.end_of_query),
    .space_i (space),
    .accept_o(accept),
    .push_o  (push),
    .group_o (push_group)
  );

  // Queue of result groups, so that the scanner runs ahead of a stalled sink.
  qct_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_group),
    .space_o(space),
    .valid_o(q_valid),
    .pop_i  (pop),
    .data_o (head_group)
  );

  // Emitter: one token per cycle from the head group while the output register is empty or being taken.
  qct_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(q_valid),
    .group_i(head_group),
    .pop_o  (pop),
    .token_o(token_o)
  );

`ifndef SYNTHESIS
  a_end_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_o.valid && token_o.token_kind == TkEndMarker |-> token_o.last_of_run)
    else $error("end marker not last of its run");

  a_ready_tracks_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> char_i.ready && char_i.valid)
    else $error("character taken without handshake");
`endif

endmodule

[test/token_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// token_checker: scoreboard for the query character tokenizer
// Watches the character and token channels, predicts the tokens of every
// accepted character and compares them in order with what the block emits.
// ----------------------------------------------------------------------------
module token_checker
  import qct_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  qct_char_if         char_if,
  qct_token_if        token_if,
  output int          errors_o,
  output int          pending_o,
  output int          tokens_o,
  output logic [11:0] kinds_seen_o
);

  localparam int ReportLimit = 30;

  typedef struct packed {
    token_kind_e kind;
    logic [7:0]  text;
    logic        last;
  } token_word_t;

  token_word_t expected_tokens[$];
  token_word_t char_tokens[$];

  // Scanner state of the prediction.
  scan_mode_e  mode;
  logic        quote_double;
  logic [47:0] word_buf;
  logic [2:0]  word_len;

  int          fail_count;
  int          token_count;
  logic [11:0] kinds_seen;

  function automatic token_word_t tok(input token_kind_e kind, input logic [7:0] text);
    token_word_t w;
    w.kind = kind;
    w.text = text;
    w.last = 1'b0;
    return w;
  endfunction

  // Appends one predicted token of the current character.
  task automatic add_token(input token_kind_e kind, input logic [7:0] text);
    char_tokens.insert(char_tokens.size(), tok(kind, text));
  endtask

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // Only a word of exactly six letters can be a keyword.
  function automatic token_kind_e word_result();
    token_kind_e k;
    k = TkUnknown;
    if (word_len == 3'd6) begin
      case (word_buf)
        KwInsert: k = TkInsert;
        KwSearch: k = TkSearch;
        KwDelete: k = TkDelete;
        KwUpdate: k = TkUpdate;
        default:  k = TkUnknown;
      endcase
    end
    return k;
  endfunction

  task automatic add_letter(input logic [7:0] c);
    logic [7:0] upper;
    upper = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if (word_len < 3'd6) word_buf = {word_buf[39:0], upper};
    if (word_len < 3'd7) word_len = word_len + 3'd1;
  endtask

  // Handles a character as if no token were open.
  task automatic open_token(input logic [7:0] c);
    if (c == CharSingle || c == CharDouble) begin
      mode = ModeQuote;
      quote_double = (c == CharDouble);
    end else if (c == CharSpace) begin
      mode = ModeIdle;
    end else if (c == CharSemi) begin
      mode = ModeSkip;
    end else if (is_digit(c)) begin
      mode = ModeId;
      add_token(TkIdChar, c);
    end else if (is_letter(c)) begin
      mode = ModeWord;
      word_buf = '0;
      word_len = '0;
      add_letter(c);
    end else begin
      mode = ModeIdle;
      add_token(TkBadChar, 8'h00);
    end
  endtask

  task automatic reset_scanner();
    mode = ModeIdle;
    quote_double = 1'b0;
    word_buf = '0;
    word_len = '0;
  endtask

  // Predicts the tokens of one accepted character and queues them.
  task automatic tokenize_char(input logic [7:0] c, input logic eoq);
    logic [7:0] closer;
    char_tokens.delete();
    case (mode)
      ModeQuote: begin
        closer = quote_double ? CharDouble : CharSingle;
        if (c == closer) begin
          add_token(TkDataEnd, 8'h00);
          mode = ModeIdle;
        end else if (c == CharSemi) begin
          add_token(TkUnclosed, 8'h00);
          mode = ModeSkip;
        end else begin
          add_token(TkDataChar, c);
        end
      end
      ModeId: begin
        if (is_digit(c)) begin
          add_token(TkIdChar, c);
        end else begin
          add_token(TkIdEnd, 8'h00);
          open_token(c);
        end
      end
      ModeWord: begin
        if (is_letter(c)) begin
          add_letter(c);
        end else begin
          add_token(word_result(), 8'h00);
          open_token(c);
        end
      end
      ModeSkip: ;
      default: open_token(c);
    endcase
    if (eoq) begin
      if (mode == ModeQuote) add_token(TkUnclosed, 8'h00);
      else if (mode == ModeId) add_token(TkIdEnd, 8'h00);
      else if (mode == ModeWord) add_token(word_result(), 8'h00);
      add_token(TkEndMarker, 8'h00);
      reset_scanner();
    end
    if (char_tokens.size() > 0) char_tokens[char_tokens.size()-1].last = 1'b1;
    foreach (char_tokens[i]) expected_tokens.insert(expected_tokens.size(), char_tokens[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    token_word_t want;
    if (!rst_ni) begin
      reset_scanner();
      expected_tokens.delete();
      fail_count = 0;
      token_count = 0;
      kinds_seen = '0;
    end else begin
      // A token is popped before the new character is predicted; the block
      // cannot emit a token of a character in the cycle it takes it.
      if (token_if.valid && token_if.ready) begin
        token_count++;
        if (token_if.token_kind < 4'd12) kinds_seen[token_if.token_kind] = 1'b1;
        if (expected_tokens.size() == 0) begin
          if (fail_count < ReportLimit)
            $error("unexpected token: kind %0d text %02h last %0b", token_if.token_kind,
                   token_if.text_char, token_if.last_of_run);
          fail_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (token_if.token_kind !== want.kind) begin
            if (fail_count < ReportLimit)
              $error("token_kind: expected %0d, actual %0d", want.kind, token_if.token_kind);
            fail_count++;
          end
          if (token_if.text_char !== want.text) begin
            if (fail_count < ReportLimit)
              $error("text_char: expected %02h, actual %02h", want.text, token_if.text_char);
            fail_count++;
          end
          if (token_if.last_of_run !== want.last) begin
            if (fail_count < ReportLimit)
              $error("last_of_run: expected %0b, actual %0b", want.last,
                     token_if.last_of_run);
            fail_count++;
          end
        end
      end
      if (char_if.valid && char_if.ready)
        tokenize_char(char_if.query_char, char_if.end_of_query);
    end
    errors_o     <= fail_count;
    pending_o    <= expected_tokens.size();
    tokens_o     <= token_count;
    kinds_seen_o <= kinds_seen;
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the query character tokenizer
// Feeds directed and random queries into the tokenizer with random gaps on
// both channels and one long output stall; the token checker predicts and
// compares every token, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import qct_pkg::*;

  // Number of random characters to send after the directed queries.
  localparam int RandomChars   = 320;
  // Output stall that forces the block to fill up and stop taking characters.
  localparam int HoldCycles    = 100;
  // Cycles without any accepted word before the run is declared hung.
  localparam int WatchdogLimit = 1000;
  // Quiet time after the last expected token, to catch stray tokens.
  localparam int DrainCycles   = 20;

  logic clk_i;
  logic rst_ni;

  qct_char_if  char_if ();
  qct_token_if token_if ();

  int          chk_errors;
  int          chk_pending;
  int          chk_tokens;
  logic [11:0] chk_kinds;

  // Set while neither side may idle, and to request the long output stall.
  logic        calm;
  logic        hold_req;

  int          chars_sent;
  int          queries_sent;
  int          idle_cycles;
  logic [7:0]  query_bytes[$];

  query_char_tokenizer_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_if),
    .token_o (token_if)
  );

  token_checker token_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_if      (char_if),
    .token_if     (token_if),
    .errors_o     (chk_errors),
    .pending_o    (chk_pending),
    .tokens_o     (chk_tokens),
    .kinds_seen_o (chk_kinds)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Sends one word on the character channel. It is called at a rising edge
  // and returns at the edge where the word was accepted, so that the next
  // call can keep valid high without a gap.
  task automatic send_char(input logic [7:0] c, input logic eoq);
    if (!calm) begin
      while ($urandom_range(99) < 13) begin
        char_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    char_if.valid        <= 1'b1;
    char_if.query_char   <= c;
    char_if.end_of_query <= eoq;
    do @(posedge clk_i); while (!char_if.ready);
    chars_sent++;
    if (eoq) queries_sent++;
  endtask

  task automatic send_text(input string s, input logic closes);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], closes && (i == s.len() - 1));
  endtask

  // Appends one byte to the query being built.
  task automatic add_byte(input logic [7:0] b);
    query_bytes.insert(query_bytes.size(), b);
  endtask

  // Letters go out in random case; the block must ignore case.
  task automatic push_letter(input logic [7:0] upper);
    add_byte(upper | 8'($urandom_range(1) << 5));
  endtask

  // Builds one random query into query_bytes. Most tokens are well formed
  // (keywords, ids, closed quotes), the rest are spoiled words, noise bytes,
  // semicolons and quotes left open.
  task automatic build_query();
    int          n_tokens;
    int          len;
    logic [47:0] kw;
    logic [7:0]  closer;
    query_bytes.delete();
    n_tokens = $urandom_range(1, 6);
    for (int t = 0; t < n_tokens; t++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          case ($urandom_range(3))
            0:       kw = KwInsert;
            1:       kw = KwSearch;
            2:       kw = KwDelete;
            default: kw = KwUpdate;
          endcase
          // Now and then a keyword is spoiled by a wrong or an extra letter.
          if ($urandom_range(4) == 0)
            kw[8*$urandom_range(5) +: 8] = 8'("A" + $urandom_range(25));
          for (int i = 5; i >= 0; i--) push_letter(kw[8*i +: 8]);
          if ($urandom_range(6) == 0) push_letter(8'("A" + $urandom_range(25)));
        end
        3: begin
          len = $urandom_range(1, 9);
          for (int i = 0; i < len; i++) push_letter(8'("A" + $urandom_range(25)));
        end
        4, 5: begin
          len = $urandom_range(1, 5);
          for (int i = 0; i < len; i++) add_byte(8'("0" + $urandom_range(9)));
        end
        6, 7: begin
          closer = $urandom_range(1) ? CharDouble : CharSingle;
          add_byte(closer);
          len = $urandom_range(0, 5);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) add_byte(8'($urandom_range(255)));
            else add_byte(8'($urandom_range(8'h20, 8'h7E)));
          end
          if ($urandom_range(9) != 0) add_byte(closer);
        end
        8: begin
          len = $urandom_range(1, 2);
          for (int i = 0; i < len; i++) add_byte(8'($urandom_range(255)));
        end
        default: begin
          add_byte(CharSemi);
          len = $urandom_range(0, 3);
          for (int i = 0; i < len; i++) add_byte(8'($urandom_range(255)));
        end
      endcase
      if ($urandom_range(9) < 7) begin
        add_byte(CharSpace);
        if ($urandom_range(5) == 0) add_byte(CharSpace);
      end
    end
  endtask

  // Receiver: random stalls, none during the calm stretch, and one long
  // hold-off on request while the sender keeps offering characters.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    token_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        token_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        token_if.ready <= calm || ($urandom_range(99) >= 13);
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (char_if.valid && char_if.ready) || (token_if.valid && token_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int random_chars;
    rst_ni               <= 1'b0;
    char_if.valid        <= 1'b0;
    char_if.query_char   <= 8'h00;
    char_if.end_of_query <= 1'b0;
    calm                 <= 1'b0;
    hold_req             <= 1'b0;
    chars_sent   = 0;
    queries_sent = 0;
    random_chars = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed queries. A keyword followed by a digit that ends the query
    // gives the most tokens one character can cause.
    send_text("insert5", 1'b1);
    // The other quote inside a quote is data; a semicolon inside a quote
    // leaves it unclosed and the end still gives the end marker.
    send_text("Search'\";", 1'b1);
    // A keyword closed by a byte above 127, which is a bad character.
    send_text("DELETE", 1'b0);
    send_char(8'hFF, 1'b1);
    // A query that is a single bad character.
    send_char(8'h00, 1'b1);
    // A quote opened on the last character stays unclosed.
    send_text("update\"", 1'b1);

    // Random queries, with one calm stretch and one long output stall.
    while (random_chars < RandomChars) begin
      if (queries_sent == 9) hold_req <= 1'b1;
      calm <= (queries_sent >= 14 && queries_sent < 20);
      build_query();
      foreach (query_bytes[i]) send_char(query_bytes[i], i == query_bytes.size() - 1);
      random_chars += query_bytes.size();
    end
    char_if.valid <= 1'b0;
    calm          <= 1'b0;

    @(posedge clk_i);
    while (chk_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Tokenized %0d characters in %0d queries; %0d tokens checked in order.",
             chars_sent, queries_sent, chk_tokens);
    $display("Token kinds seen (one bit per kind, kind 0 rightmost): %012b.", chk_kinds);
    if (chk_pending != 0) $error("%0d expected tokens never arrived", chk_pending);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/qct_pkg.sv
rtl/qct_char_if.sv
rtl/qct_token_if.sv
rtl/qct_front.sv
rtl/qct_fifo.sv
rtl/qct_back.sv
rtl/query_char_tokenizer_unit.sv
test/token_checker.sv
test/tb_top.sv
